@@ src/chacha20_keystream_xor_macros.svh @@
`ifndef CHACHA20_KEYSTREAM_XOR_MACROS_SVH
`define CHACHA20_KEYSTREAM_XOR_MACROS_SVH

// same-cycle implication
`define CKX_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// next-cycle implication
`define CKX_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

@@ src/ckx_pkg.sv @@
`default_nettype none

package ckx_pkg;

   typedef logic [15:0][31:0] ckx_state_type;

   typedef struct packed {
      logic [31:0] block_counter;
      logic [31:0] plaintext_word;
      logic [3:0]  word_pos;
   } ckx_entry_type;

   typedef enum logic [2:0] {
      CSR_KEY_0_1   = 3'd0,
      CSR_KEY_2_3   = 3'd1,
      CSR_KEY_4_5   = 3'd2,
      CSR_KEY_6_7   = 3'd3,
      CSR_NONCE_0_1 = 3'd4,
      CSR_NONCE_2   = 3'd5
   } ckx_csr_index_type;

   localparam logic [31:0] SIGMA [4] = '{
      32'h61707865, 32'h3320646E, 32'h79622D32, 32'h6B206574
   };

   localparam logic [4:0] ROT_AMOUNT [4] = '{5'd16, 5'd12, 5'd8, 5'd7};

   localparam logic [3:0] FIRST_POS = 4'd0;
   localparam logic [3:0] LAST_POS  = 4'd15;

   localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

@@ src/ckx_front.sv @@
`default_nettype none

module ckx_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [31:0]            req_block_counter,
   input  wire logic [31:0]            req_plaintext_word,
   input  wire logic                   q_full,
   output logic                        q_push,
   output ckx_pkg::ckx_entry_type      q_entry
);

   logic [3:0] pos_ff, pos_in;

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   always_comb begin
      q_entry.block_counter  = req_block_counter;
      q_entry.plaintext_word = req_plaintext_word;
      q_entry.word_pos       = pos_ff;
      pos_in = q_push ? pos_ff + 4'd1 : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= ckx_pkg::FIRST_POS;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

@@ src/ckx_queue.sv @@
`default_nettype none

module ckx_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire ckx_pkg::ckx_entry_type entry_in,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        valid,
   output ckx_pkg::ckx_entry_type      head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ckx_pkg::ckx_entry_type slots_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

@@ src/ckx_core.sv @@
`default_nettype none

module ckx_core #(
   parameter int ROUND_COUNT = 20
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ckx_pkg::ckx_state_type init_state,
   input  wire logic                   q_valid,
   input  wire ckx_pkg::ckx_entry_type q_head,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [31:0]                 rsp_ciphertext_word,
   output logic                        rsp_last_of_block
);

   localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
   localparam int DRW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
   localparam logic [2:0] STEP_LAST = 3'b111;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ROUND = 3'b010,
      ST_FINAL = 3'b100
   } state_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
      return (v << s) | (v >> (6'd32 - {1'b0, s}));
   endfunction

   function automatic ckx_pkg::ckx_state_type to_diag(input ckx_pkg::ckx_state_type s);
      ckx_pkg::ckx_state_type r;
      for (int q = 0; q < 4; q++) begin
         r[q]      = s[q];
         r[4 + q]  = s[4 + ((q + 1) & 3)];
         r[8 + q]  = s[8 + ((q + 2) & 3)];
         r[12 + q] = s[12 + ((q + 3) & 3)];
      end
      return r;
   endfunction

   function automatic ckx_pkg::ckx_state_type from_diag(input ckx_pkg::ckx_state_type s);
      ckx_pkg::ckx_state_type r;
      for (int q = 0; q < 4; q++) begin
         r[q]                   = s[q];
         r[4 + ((q + 1) & 3)]   = s[4 + q];
         r[8 + ((q + 2) & 3)]   = s[8 + q];
         r[12 + ((q + 3) & 3)]  = s[12 + q];
      end
      return r;
   endfunction

   state_type              state_ff, state_in;
   logic [2:0]             step_ff, step_in;
   logic [DRW-1:0]         dr_ff, dr_in;
   logic                   fresh_ff, fresh_in;
   logic                   out_valid_ff, out_valid_in;
   ckx_pkg::ckx_state_type work_ff, work_in;
   logic [31:0]            ctr_ff, ctr_in;
   logic [31:0]            out_word_ff, out_word_in;
   logic                   out_last_ff, out_last_in;

   ckx_pkg::ckx_state_type rnd_work;
   ckx_pkg::ckx_state_type init_full;
   logic                   out_free;

   assign rsp_empty           = !out_valid_ff;
   assign rsp_ciphertext_word = out_word_ff;
   assign rsp_last_of_block   = out_last_ff;
   assign out_free            = !out_valid_ff || rsp_pop;

   // one quarter-round line across all four lanes
   always_comb begin : round_logic
      ckx_pkg::ckx_state_type view, res;
      logic [1:0]  line;
      logic [4:0]  amt;
      logic [31:0] sum;
      line = step_ff[1:0];
      amt  = ckx_pkg::ROT_AMOUNT[line];
      view = step_ff[2] ? to_diag(work_ff) : work_ff;
      res  = view;
      for (int q = 0; q < 4; q++) begin
         if (!line[0]) begin
            sum        = view[q] + view[4 + q];
            res[q]     = sum;
            res[12 + q] = rotl(view[12 + q] ^ sum, amt);
         end else begin
            sum        = view[8 + q] + view[12 + q];
            res[8 + q] = sum;
            res[4 + q] = rotl(view[4 + q] ^ sum, amt);
         end
      end
      rnd_work = step_ff[2] ? from_diag(res) : res;
   end

   always_comb begin
      init_full     = init_state;
      init_full[12] = ctr_ff;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      dr_in        = dr_ff;
      fresh_in     = fresh_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      work_in      = work_ff;
      ctr_in       = ctr_ff;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if ((q_head.word_pos == ckx_pkg::FIRST_POS) && !fresh_ff) begin
                  work_in     = init_state;
                  work_in[12] = q_head.block_counter;
                  ctr_in      = q_head.block_counter;
                  step_in     = '0;
                  dr_in       = '0;
                  state_in    = ST_ROUND;
               end else if (out_free) begin
                  q_pop        = 1'b1;
                  out_valid_in = 1'b1;
                  out_word_in  = q_head.plaintext_word ^ work_ff[q_head.word_pos];
                  out_last_in  = (q_head.word_pos == ckx_pkg::LAST_POS);
                  if (q_head.word_pos == ckx_pkg::FIRST_POS) begin
                     fresh_in = 1'b0;
                  end
               end
            end
         end
         ST_ROUND: begin
            work_in = rnd_work;
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_LAST) begin
               dr_in = dr_ff + DRW'(1);
               if (dr_ff == DRW'(DOUBLE_ROUNDS - 1)) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < 16; i++) begin
               work_in[i] = work_ff[i] + init_full[i];
            end
            fresh_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         dr_ff        <= '0;
         fresh_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         dr_ff        <= dr_in;
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      ctr_ff      <= ctr_in;
      out_word_ff <= out_word_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

@@ src/chacha20_keystream_xor.sv @@
`default_nettype none

// ChaCha keystream XOR. Plaintext words go in sixteen to a block; the first word of
// a block also carries the block counter. A front stage numbers the words and drops
// them into a two-entry queue; the back end, on a block's first word, builds the
// state from the constants, key, counter and nonce, then runs the rounds one
// quarter-round line per cycle (four lanes in parallel): each double round runs the
// column lines, then the diagonal lines, and after the last one the input state is
// added back. Each word is then XORed with its keystream word and registered to the
// output once the output register is free. The single round unit serves one block
// at a time; meanwhile the queue takes words until it is full.
// Registers may be written only while no word is in flight; a write takes effect
// from the next block's first word. csr_ready is always high and unknown indexes
// are dropped.

`include "chacha20_keystream_xor_macros.svh"

module chacha20_keystream_xor #(
   parameter int ROUND_COUNT = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [31:0] req_block_counter,
   input  wire logic [31:0] req_plaintext_word,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_ciphertext_word,
   output logic             rsp_last_of_block,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   logic [63:0] key01_ff, key23_ff, key45_ff, key67_ff, nonce01_ff;
   logic [31:0] nonce2_ff;
   ckx_pkg::ckx_state_type init_state;

   logic                   q_push, q_full, q_pop, q_valid;
   ckx_pkg::ckx_entry_type q_entry, q_head;
   logic                   pop_last;

   assign csr_ready = 1'b1;
   assign pop_last  = q_pop && (q_head.word_pos == ckx_pkg::LAST_POS);

   always_ff @(posedge clock) begin
      if (reset) begin
         key01_ff   <= '0;
         key23_ff   <= '0;
         key45_ff   <= '0;
         key67_ff   <= '0;
         nonce01_ff <= '0;
         nonce2_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ckx_pkg::CSR_KEY_0_1:   key01_ff   <= csr_wdata;
            ckx_pkg::CSR_KEY_2_3:   key23_ff   <= csr_wdata;
            ckx_pkg::CSR_KEY_4_5:   key45_ff   <= csr_wdata;
            ckx_pkg::CSR_KEY_6_7:   key67_ff   <= csr_wdata;
            ckx_pkg::CSR_NONCE_0_1: nonce01_ff <= csr_wdata;
            ckx_pkg::CSR_NONCE_2:   nonce2_ff  <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   // word 12 is filled in by the core
   always_comb begin
      init_state[0]  = ckx_pkg::SIGMA[0];
      init_state[1]  = ckx_pkg::SIGMA[1];
      init_state[2]  = ckx_pkg::SIGMA[2];
      init_state[3]  = ckx_pkg::SIGMA[3];
      init_state[4]  = key01_ff[31:0];
      init_state[5]  = key01_ff[63:32];
      init_state[6]  = key23_ff[31:0];
      init_state[7]  = key23_ff[63:32];
      init_state[8]  = key45_ff[31:0];
      init_state[9]  = key45_ff[63:32];
      init_state[10] = key67_ff[31:0];
      init_state[11] = key67_ff[63:32];
      init_state[12] = '0;
      init_state[13] = nonce01_ff[31:0];
      init_state[14] = nonce01_ff[63:32];
      init_state[15] = nonce2_ff;
   end

   ckx_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_block_counter  (req_block_counter),
      .req_plaintext_word (req_plaintext_word),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_entry            (q_entry)
   );

   ckx_queue #(
      .DEPTH (ckx_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .entry_in (q_entry),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   ckx_core #(
      .ROUND_COUNT (ROUND_COUNT)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .init_state          (init_state),
      .q_valid             (q_valid),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_ciphertext_word (rsp_ciphertext_word),
      .rsp_last_of_block   (rsp_last_of_block)
   );

   `CKX_ASSERT_IMPLY(a_full_blocks_push, clock, reset, req_full, !q_push)
   `CKX_ASSERT_NEXT(a_pop_loads_output, clock, reset, q_pop, !rsp_empty)
   `CKX_ASSERT_NEXT(a_last_marked, clock, reset, pop_last, rsp_last_of_block)

endmodule

`default_nettype wire
